// ===== design/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("implication failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/ptmn_pkg.sv =====
`timescale 1ns / 1ps
package ptmn_pkg;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned EXP_W = 5;
  localparam int unsigned NOTE_W = 7;
  localparam int unsigned BEND_W = 14;
  localparam int unsigned OUT_W = 24;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_ZERO  = 2'd2
  } range_status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOG,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic              zero;
    logic              period;
    logic [EXP_W-1:0]  exp;
    logic [DATA_W-1:0] mant;
  } ptmn_item_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [6:0]        bend_high;
    logic [6:0]        bend_low;
    range_status_e     status;
  } ptmn_result_t;
endpackage

// ===== design/ptmn_front.sv =====
`timescale 1ns / 1ps
module ptmn_front import ptmn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  input  logic              mode_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output ptmn_item_t        push_item_o
);
  logic       vld_q;
  ptmn_item_t item_q, item_d;
  logic [EXP_W-1:0] exp_d;

  // leading one position
  always_comb begin
    exp_d = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (in_data_i[i]) begin
        exp_d = EXP_W'(i);
      end
    end
  end

  always_comb begin
    item_d.zero   = (in_data_i == '0);
    item_d.period = mode_i;
    item_d.exp    = exp_d;
    item_d.mant   = in_data_i << (~exp_d);
  end

  assign in_ready_o   = !vld_q || push_ready_i;
  assign push_valid_o = vld_q;
  assign push_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      vld_q <= 1'b1;
    end else if (push_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end
endmodule

// ===== design/ptmn_queue.sv =====
`timescale 1ns / 1ps
module ptmn_queue import ptmn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  ptmn_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output ptmn_item_t pop_item_o
);
  ptmn_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end
endmodule

// ===== design/ptmn_back.sv =====
`timescale 1ns / 1ps
module ptmn_back import ptmn_pkg::*; #(
  parameter int unsigned INPUT_FRAC_BITS = 16,
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pop_valid_i,
  output logic         pop_o,
  input  ptmn_item_t   pop_item_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ptmn_result_t out_result_o
);
  localparam int unsigned L  = LOG_FRAC_BITS;
  localparam int unsigned RW = EXP_W + L;
  localparam int unsigned NW = L + 13;
  localparam int unsigned CW = $clog2(L);
  localparam logic [63:0] L1000_64 =
    (64'd42802717582 + (64'd1 << (31 - L))) >> (32 - L);
  localparam logic [63:0] L440_64 =
    (64'd37715652784 + (64'd1 << (31 - L))) >> (32 - L);
  localparam logic signed [NW-1:0] C1000  = NW'(L1000_64);
  localparam logic signed [NW-1:0] C440   = NW'(L440_64);
  localparam logic signed [NW-1:0] IN_OFF = NW'(INPUT_FRAC_BITS << L);
  localparam logic signed [NW-1:0] N69    = NW'(69 << L);
  localparam logic [L:0]           HALF   = (L + 1)'(1) << (L - 1);

  back_state_e  state_q, state_d;
  logic [CW-1:0] cnt_q;
  logic [31:0]   m_q;
  logic [RW-1:0] r_q;
  logic          zero_q, period_q;
  logic          out_valid_q;
  ptmn_result_t  out_q, res_d;
  logic          out_free, load_out, step;
  logic [63:0]   sq;
  logic [32:0]   t;

  logic signed [NW-1:0] lv, lf, d, n, ip, ipa;
  logic [L:0]           fr0, fr;
  logic [BEND_W-1:0]    bend;

  assign out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          state_d = pop_item_i.zero ? BK_DONE : BK_LOG;
        end
      end
      BK_LOG: begin
        if (cnt_q == CW'(L - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    step     = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: pop_o = pop_valid_i;
      BK_LOG:  step = 1'b1;
      BK_DONE: load_out = out_free;
      default: pop_o = 1'b0;
    endcase
  end

  // one squaring step per cycle
  assign sq = m_q * m_q;
  assign t  = sq[63:31];

  always_comb begin
    lv  = $signed(NW'(r_q)) - IN_OFF;
    lf  = period_q ? (C1000 - lv) : lv;
    d   = lf - C440;
    n   = (d <<< 3) + (d <<< 2) + N69;
    ip  = n >>> L;
    fr0 = {1'b0, n[L-1:0]};
    if (fr0 > HALF) begin
      fr  = fr0 - HALF;
      ipa = ip + NW'(1);
    end else begin
      fr  = fr0 + HALF;
      ipa = ip;
    end
    bend = fr[L] ? {BEND_W{1'b1}} : fr[L-1 -: BEND_W];
    if (zero_q) begin
      res_d.note      = '0;
      res_d.bend_high = 7'd64;
      res_d.bend_low  = '0;
      res_d.status    = ST_ZERO;
    end else begin
      res_d.bend_high = bend[13:7];
      res_d.bend_low  = bend[6:0];
      if (ipa < 0) begin
        res_d.note   = '0;
        res_d.status = ST_CLAMP;
      end else if (ipa > NW'(127)) begin
        res_d.note   = 7'd127;
        res_d.status = ST_CLAMP;
      end else begin
        res_d.note   = ipa[NOTE_W-1:0];
        res_d.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        cnt_q <= '0;
      end else if (step) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      m_q      <= pop_item_i.mant;
      r_q      <= RW'(pop_item_i.exp);
      zero_q   <= pop_item_i.zero;
      period_q <= pop_item_i.period;
    end else if (step) begin
      m_q <= t[32] ? t[32:1] : t[31:0];
      r_q <= {r_q[RW-2:0], t[32]};
    end
    if (load_out) begin
      out_q <= res_d;
    end
  end
endmodule

// ===== design/pitch_to_midi_note_bend.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   pitch_value
// m_axis    out  m_axis_tvalid/m_axis_tready   midi_note, bend_high, bend_low, range_status
// cfg       in   cfg_we_i                      input_is_period
// an item takes one squaring multiply per fraction bit in the log unit;
// that unit sets the sustained rate
// the front register and a two-entry queue take items while the log unit works
// reset clears all valid flags and the mode register
// a stalled output holds its result while the log unit finishes the next one
`include "assert_macros.svh"
module pitch_to_midi_note_bend import ptmn_pkg::*; #(
  parameter int unsigned INPUT_FRAC_BITS = 16,
  parameter int unsigned LOG_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // pitch_value
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // midi_note, bend_high, bend_low, range_status, pad
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);
  logic         mode_q;
  logic         push_valid, push_ready, pop_valid, pop;
  ptmn_item_t   push_item, pop_item;
  ptmn_result_t res;
  logic         out_zero, out_clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  ptmn_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .mode_i       (mode_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  ptmn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  ptmn_back #(
    .INPUT_FRAC_BITS (INPUT_FRAC_BITS),
    .LOG_FRAC_BITS   (LOG_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .pop_item_i   (pop_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (res)
  );

  assign m_axis_tdata = {1'b0, res.status, res.bend_low, res.bend_high, res.note};

  assign out_zero  = m_axis_tvalid && (res.status == ST_ZERO);
  assign out_clamp = m_axis_tvalid && (res.status == ST_CLAMP);

  `ASSERT_NEVER(a_status_code, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[22:21] == 2'd3))
  `ASSERT_IMPLIES(a_zero_center, clk_i, rst_ni, out_zero, m_axis_tdata[20:0] == 21'h2000)
  `ASSERT_IMPLIES(a_clamp_edge, clk_i, rst_ni, out_clamp, (res.note == 7'd0) || (res.note == 7'd127))
endmodule
